FILE: hw/rtl/cpf_pkg.sv
// Shared widths, defaults, controller states and control structs for class probability fusion.
package cpf_pkg;

    // Field widths fixed by the interface
    localparam int unsigned IDW   = 12;
    localparam int unsigned PROBW = 16;
    localparam int unsigned SUMW  = 20;
    localparam int unsigned CLSW  = 4;

    // Default configuration
    localparam int unsigned NUM_CLASSES_DEF  = 14;
    localparam int unsigned NUM_ELEMENTS_DEF = 4096;

    // Controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_QUOT,
        S_BASE,
        S_READ,
        S_MUL,
        S_WRITE,
        S_NCHECK,
        S_NREAD,
        S_NSTART,
        S_NDIV,
        S_RESULT,
        S_ZERO
    } t_cpf_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic take_item;   // latch element id and likelihood
        logic calc_quot;   // element id reduction, quotient step
        logic calc_base;   // element base address
        logic calc_prod;   // entry times likelihood
        logic wr_item;     // write product, add to running sum, advance class
        logic clr_write;   // reset sweep write
        logic use_k;       // address by normalisation index
        logic div_start;   // start one division
        logic wr_norm;     // write normalised entry, update argmax
        logic load_result; // load result register from argmax
        logic load_zero;   // load the empty result
    } t_cpf_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic clr_last;
        logic cls_last;
        logic k_last;
        logic denom_zero;
        logic div_busy;
        logic out_free;
    } t_cpf_sts;

endpackage

FILE: hw/rtl/cpf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cpf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/cpf_div.sv
// Restoring divider, one quotient bit a cycle, for (entry << 16) / sum with saturation.
module cpf_div import cpf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [PROBW-1:0] i_dividend,
    input  logic [SUMW-1:0]  i_divisor,
    output logic             o_busy,
    output logic [PROBW-1:0] o_quotient
);

    localparam int unsigned StepW = $clog2(PROBW);

    logic             r_busy;
    logic [StepW-1:0] r_cnt;
    logic [SUMW-1:0]  r_rem;
    logic [SUMW-1:0]  r_divisor;
    logic [PROBW-1:0] r_quo;
    logic             r_sat;

    logic [SUMW:0]    w_shift;
    logic             w_ge;
    logic [SUMW:0]    w_diff;

    // Trial subtract of the shifted remainder
    always_comb begin
        w_shift = {r_rem, 1'b0};
        w_ge    = w_shift >= {1'b0, r_divisor};
        w_diff  = w_shift - {1'b0, r_divisor};
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == StepW'(PROBW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Remainder and quotient; an entry not below the sum saturates
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_divisor <= i_divisor;
            r_rem     <= SUMW'(i_dividend);
            r_sat     <= {{(SUMW - PROBW){1'b0}}, i_dividend} >= i_divisor;
            r_quo     <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SUMW-1:0] : w_shift[SUMW-1:0];
            r_quo <= {r_quo[PROBW-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_sat ? {PROBW{1'b1}} : r_quo;

endmodule

FILE: hw/rtl/cpf_datapath.sv
// Datapath: table RAM, address arithmetic, multiply, running sum, divider, argmax, result register.
module cpf_datapath import cpf_pkg::*; #(
    parameter int unsigned NUM_CLASSES  = NUM_CLASSES_DEF,
    parameter int unsigned NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cpf_cmd         i_cmd,
    output t_cpf_sts         o_sts,
    input  logic [IDW-1:0]   i_element_id,
    input  logic [PROBW-1:0] i_likelihood,
    input  logic             i_cfg_wr_en,
    input  logic [PROBW-1:0] i_cfg_wr_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_has_class,
    output logic [CLSW-1:0]  o_winning_class,
    output logic [PROBW-1:0] o_winning_prob
);

    localparam int unsigned Depth      = NUM_ELEMENTS * NUM_CLASSES;
    localparam int unsigned AW         = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CW         = $clog2(NUM_CLASSES);
    localparam int unsigned UniRaw     = 65536 / NUM_CLASSES;
    localparam logic [PROBW-1:0] Uniform = PROBW'((UniRaw > 65535) ? 65535 : UniRaw);
    localparam bit          Wrap       = NUM_ELEMENTS < (1 << IDW);
    localparam int unsigned RecipShift = 2 * IDW;
    localparam longint unsigned RecipRaw =
        ((64'd1 << RecipShift) + NUM_ELEMENTS - 1) / NUM_ELEMENTS;
    localparam logic [RecipShift:0] Recip = RecipRaw[RecipShift:0];
    localparam int unsigned ProdW      = IDW + RecipShift + 1;

    // Item registers
    logic [IDW-1:0]   r_id;
    logic [PROBW-1:0] r_lik;
    logic [IDW-1:0]   r_quot;
    logic [AW-1:0]    r_base;
    logic [PROBW-1:0] r_prod;
    logic [SUMW-1:0]  r_sum;
    logic [SUMW-1:0]  r_denom;
    logic [CW-1:0]    r_cls;
    logic [CW-1:0]    r_k;
    logic [PROBW-1:0] r_best_prob;
    logic [CW-1:0]    r_best_cls;
    logic [AW-1:0]    r_clr_addr;
    logic [PROBW-1:0] r_thresh;
    logic             r_out_valid;
    logic             r_has;
    logic [CLSW-1:0]  r_wcls;
    logic [PROBW-1:0] r_wprob;

    logic [ProdW-1:0]   w_recip_prod;
    logic [31:0]        w_base_full;
    logic [AW-1:0]      w_addr;
    logic [31:0]        w_mul_full;
    logic [SUMW-1:0]    w_sum_next;
    logic [PROBW-1:0]   w_rd_data;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [PROBW-1:0]   w_wr_data;
    logic               w_cls_last;
    logic               w_k_last;
    logic               w_div_busy;
    logic [PROBW-1:0]   w_div_q;

    // Element id reduction by reciprocal, then base address of the element row
    always_comb begin
        w_recip_prod = {{(RecipShift + 1){1'b0}}, r_id} * {{IDW{1'b0}}, Recip};
        w_base_full  = {{(32 - IDW){1'b0}}, r_id} * 32'(NUM_CLASSES)
                     - {{(32 - IDW){1'b0}}, r_quot} * 32'(Depth);
    end

    // Entry address, product and running sum
    always_comb begin
        w_addr     = r_base + AW'(i_cmd.use_k ? r_k : r_cls);
        w_mul_full = {16'b0, w_rd_data} * {16'b0, r_lik};
        w_sum_next = r_sum + SUMW'(r_prod);
        w_cls_last = r_cls == CW'(NUM_CLASSES - 1);
        w_k_last   = r_k == CW'(NUM_CLASSES - 1);
    end

    // Table write port selection
    always_comb begin
        w_wr_en   = i_cmd.clr_write | i_cmd.wr_item | i_cmd.wr_norm;
        w_wr_addr = i_cmd.clr_write ? r_clr_addr : w_addr;
        if (i_cmd.clr_write) begin
            w_wr_data = Uniform;
        end else if (i_cmd.wr_item) begin
            w_wr_data = r_prod;
        end else begin
            w_wr_data = w_div_q;
        end
    end

    cpf_ram #(
        .WIDTH (PROBW),
        .DEPTH (Depth)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_addr),
        .o_rd_data (w_rd_data)
    );

    cpf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_rd_data),
        .i_divisor  (r_denom),
        .o_busy     (w_div_busy),
        .o_quotient (w_div_q)
    );

    // Control state: counters, sum, threshold, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls       <= '0;
            r_k         <= '0;
            r_sum       <= '0;
            r_clr_addr  <= '0;
            r_thresh    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_thresh <= i_cfg_wr_data;
            end
            if (i_cmd.clr_write) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.wr_item) begin
                r_cls <= w_cls_last ? '0 : r_cls + 1'b1;
                r_sum <= w_cls_last ? '0 : w_sum_next;
                if (w_cls_last) begin
                    r_k <= '0;
                end
            end
            if (i_cmd.wr_norm) begin
                r_k <= w_k_last ? '0 : r_k + 1'b1;
            end
            if (i_cmd.load_result || i_cmd.load_zero) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_id  <= i_element_id;
            r_lik <= i_likelihood;
        end
        if (i_cmd.calc_quot) begin
            r_quot <= Wrap ? w_recip_prod[RecipShift +: IDW] : '0;
        end
        if (i_cmd.calc_base) begin
            r_base <= w_base_full[AW-1:0];
        end
        if (i_cmd.calc_prod) begin
            r_prod <= w_mul_full[31:16];
        end
        if (i_cmd.wr_item && w_cls_last) begin
            r_denom     <= w_sum_next;
            r_best_prob <= '0;
            r_best_cls  <= '0;
        end
        // Argmax, ties going to the later class
        if (i_cmd.wr_norm && (w_div_q >= r_best_prob)) begin
            r_best_prob <= w_div_q;
            r_best_cls  <= r_k;
        end
        if (i_cmd.load_result) begin
            r_has   <= r_best_prob >= r_thresh;
            r_wcls  <= CLSW'(r_best_cls);
            r_wprob <= r_best_prob;
        end else if (i_cmd.load_zero) begin
            r_has   <= 1'b0;
            r_wcls  <= '0;
            r_wprob <= '0;
        end
    end

    // Status
    always_comb begin
        o_sts.clr_last   = r_clr_addr == AW'(Depth - 1);
        o_sts.cls_last   = w_cls_last;
        o_sts.k_last     = w_k_last;
        o_sts.denom_zero = r_denom == '0;
        o_sts.div_busy   = w_div_busy;
        o_sts.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_has_class     = r_has;
    assign o_winning_class = r_wcls;
    assign o_winning_prob  = r_wprob;

endmodule

FILE: hw/rtl/cpf_ctrl.sv
// Controller: sequences the reset sweep, the per-class update and the normalisation pass.
module cpf_ctrl import cpf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_cpf_sts i_sts,
    output t_cpf_cmd o_cmd
);

    t_cpf_state r_state;
    t_cpf_state n_state;
    logic       w_ready;
    logic       w_take;

    // Input ready: idle, or finishing a class that is not the last
    always_comb begin
        w_ready = (r_state == S_IDLE) || ((r_state == S_WRITE) && !i_sts.cls_last);
        w_take  = w_ready && i_in_valid;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_take) n_state = S_QUOT;
            end
            S_QUOT:  n_state = S_BASE;
            S_BASE:  n_state = S_READ;
            S_READ:  n_state = S_MUL;
            S_MUL:   n_state = S_WRITE;
            S_WRITE: begin
                if (i_sts.cls_last) begin
                    n_state = S_NCHECK;
                end else if (w_take) begin
                    n_state = S_QUOT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_NCHECK: begin
                n_state = i_sts.denom_zero ? S_ZERO : S_NREAD;
            end
            S_NREAD:  n_state = S_NSTART;
            S_NSTART: n_state = S_NDIV;
            S_NDIV: begin
                if (!i_sts.div_busy) begin
                    n_state = i_sts.k_last ? S_RESULT : S_NREAD;
                end
            end
            S_RESULT, S_ZERO: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        o_cmd.take_item = w_take;
        case (r_state)
            S_CLEAR:  o_cmd.clr_write = 1'b1;
            S_QUOT:   o_cmd.calc_quot = 1'b1;
            S_BASE:   o_cmd.calc_base = 1'b1;
            S_MUL:    o_cmd.calc_prod = 1'b1;
            S_WRITE:  o_cmd.wr_item   = 1'b1;
            S_NREAD:  o_cmd.use_k     = 1'b1;
            S_NSTART: begin
                o_cmd.use_k     = 1'b1;
                o_cmd.div_start = 1'b1;
            end
            S_NDIV: begin
                o_cmd.use_k   = 1'b1;
                o_cmd.wr_norm = !i_sts.div_busy;
            end
            S_RESULT: o_cmd.load_result = i_sts.out_free;
            S_ZERO:   o_cmd.load_zero   = i_sts.out_free;
            default:  o_cmd.take_item   = w_take;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = w_ready;

endmodule

FILE: hw/rtl/class_probability_fusion.sv
// Top level of class probability fusion: controller, datapath and port assertions.
//
//  Channel   Signals                                        Transfer when
//  --------  ---------------------------------------------  ---------------------
//  input     i_valid, o_ready, i_element_id, i_likelihood   i_valid && o_ready
//  result    o_valid, i_ready, o_has_class,                 o_valid && i_ready
//            o_winning_class, o_winning_prob
//  config    i_cfg_wr_en, i_cfg_wr_data (color_threshold)   i_cfg_wr_en
//
// A class item passes element id reduction (quotient, then base address), table read, multiply,
// then write and sum; the next item is taken in the write cycle of any class but the last.
// After the last class the normalisation pass reads, starts the one-bit-a-cycle divider
// (16 steps) and writes each class in turn, after a check that the sum is not zero.
// After reset a sweep writes the uniform value to all NUM_ELEMENTS * NUM_CLASSES table
// entries, one a cycle, with o_ready low; configuration writes are taken throughout.
// A result still waiting holds the pass at its end; no item is taken until it is loaded.
module class_probability_fusion import cpf_pkg::*; #(
    parameter int unsigned NUM_CLASSES  = NUM_CLASSES_DEF,
    parameter int unsigned NUM_ELEMENTS = NUM_ELEMENTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [IDW-1:0]   i_element_id,
    input  logic [PROBW-1:0] i_likelihood,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_has_class,
    output logic [CLSW-1:0]  o_winning_class,
    output logic [PROBW-1:0] o_winning_prob,
    input  logic             i_cfg_wr_en,
    input  logic [PROBW-1:0] i_cfg_wr_data
);

    t_cpf_cmd w_cmd;
    t_cpf_sts w_sts;

    cpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .o_in_ready (o_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cpf_datapath #(
        .NUM_CLASSES  (NUM_CLASSES),
        .NUM_ELEMENTS (NUM_ELEMENTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_element_id    (i_element_id),
        .i_likelihood    (i_likelihood),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_out_ready     (i_ready),
        .o_out_valid     (o_valid),
        .o_has_class     (o_has_class),
        .o_winning_class (o_winning_class),
        .o_winning_prob  (o_winning_prob)
    );

    // No transfer accepted during the reset sweep
    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_write |-> !o_ready)
        else $error("input accepted during table sweep");

    // Never overwrite a result that is still waiting
    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.load_result || w_cmd.load_zero) |-> (!o_valid || i_ready))
        else $error("result register overwritten");

    // Division only with a non-zero sum
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_sts.denom_zero)
        else $error("division by zero sum started");

    // One table writer at a time
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.wr_item, w_cmd.wr_norm, w_cmd.clr_write}))
        else $error("table write conflict");

endmodule

FILE: tb/sv/tb_class_probability_fusion.sv
// Self-checking testbench for class_probability_fusion: random handshakes, table predictor.
`timescale 1ns / 1ps

module tb_class_probability_fusion;
    import cpf_pkg::*;

    localparam int unsigned NUM_CLASSES  = NUM_CLASSES_DEF;
    localparam int unsigned NUM_ELEMENTS = NUM_ELEMENTS_DEF;
    localparam int unsigned TABLE_DEPTH  = NUM_CLASSES * NUM_ELEMENTS;
    // Settling time after the last result, for the normalisation pass; leave a wide margin
    localparam int unsigned DRAIN_CYCLES = 400;
    // Reset sweep alone visits every table entry with no transfer
    localparam int unsigned WATCH_LIMIT  = 250000;
    localparam int unsigned PHASES       = 5;
    localparam int unsigned PHASE_PASSES = 15;

    typedef struct packed {
        logic [IDW-1:0]   id;
        logic [PROBW-1:0] lik;
    } t_fusion_item;

    typedef struct packed {
        logic             has_class;
        logic [CLSW-1:0]  cls;
        logic [PROBW-1:0] prob;
    } t_fusion_result;

    typedef enum {
        PASS_MIXED,   // one element, assorted likelihoods
        PASS_PEAKED,  // one or two classes carry the same likelihood, rest zero
        PASS_FLAT,    // every class gets the same likelihood
        PASS_SILENT,  // all likelihoods zero
        PASS_SCATTER  // element id drawn anew on every item
    } t_pass_kind;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [IDW-1:0]   i_element_id = '0;
    logic [PROBW-1:0] i_likelihood = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic             o_has_class;
    logic [CLSW-1:0]  o_winning_class;
    logic [PROBW-1:0] o_winning_prob;
    logic             i_cfg_wr_en = 1'b0;
    logic [PROBW-1:0] i_cfg_wr_data = '0;

    // Predictor state
    logic [PROBW-1:0] prob_model [0:TABLE_DEPTH-1];
    logic [SUMW-1:0]  norm_acc;
    int unsigned      next_class;
    logic [PROBW-1:0] report_floor;

    t_fusion_item     likelihood_q [$];
    t_fusion_result   fusion_results_due [$];

    logic             in_xfer = 1'b0;
    logic             out_xfer = 1'b0;
    int unsigned      gap_left = 0;
    int unsigned      stall_left = 0;
    bit               send_calm = 1'b0;
    bit               recv_calm = 1'b0;
    int unsigned      mismatch_count = 0;
    int unsigned      quiet_cycles = 0;

    logic [IDW-1:0]   hot_ids [0:5] = '{12'd1, 12'd2, 12'd100, 12'd2047, 12'd2048, 12'd4094};

    class_probability_fusion uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_element_id    (i_element_id),
        .i_likelihood    (i_likelihood),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_has_class     (o_has_class),
        .o_winning_class (o_winning_class),
        .o_winning_prob  (o_winning_prob),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Idle cycles for one transfer; a calm stretch waits not at all
    function automatic int unsigned pick_wait(input bit calm);
        if (calm) return 0;
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 18);
        return $urandom_range(0, 2);
    endfunction

    function automatic logic [PROBW-1:0] pick_likelihood();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2, 3: return PROBW'($urandom_range(0, 255));
            default: return PROBW'($urandom_range(0, 65535));
        endcase
    endfunction

    // Fold one likelihood into the table; close the pass on the last class
    task automatic fuse_item(input logic [IDW-1:0] id, input logic [PROBW-1:0] lik);
        int unsigned     base;
        int unsigned     k;
        int unsigned     best_cls;
        int unsigned     best;
        logic [31:0]     prod;
        logic [SUMW-1:0] denom;
        longint unsigned entry;
        longint unsigned quot;
        t_fusion_result  res;
        base = (id % NUM_ELEMENTS) * NUM_CLASSES;
        if (next_class >= NUM_CLASSES) next_class = 0;
        prod = (32'(prob_model[base + next_class]) * 32'(lik)) >> 16;
        prob_model[base + next_class] = prod[PROBW-1:0];
        norm_acc = norm_acc + prod[SUMW-1:0];
        if (next_class + 1 < NUM_CLASSES) begin
            next_class++;
            return;
        end
        denom = norm_acc;
        norm_acc = '0;
        next_class = 0;
        res = '0;
        if (denom != 0) begin
            best = 0;
            best_cls = 0;
            for (k = 0; k < NUM_CLASSES; k++) begin
                entry = prob_model[base + k];
                quot = (entry << 16) / denom;
                if (quot > 65535) quot = 65535;
                prob_model[base + k] = PROBW'(quot);
                // ties go to the later class
                if (quot >= best) begin
                    best = int'(quot);
                    best_cls = k;
                end
            end
            res.has_class = (best >= report_floor);
            res.cls = CLSW'(best_cls);
            res.prob = PROBW'(best);
        end
        fusion_results_due.insert(fusion_results_due.size(), res);
    endtask

    task automatic report_mismatch(input string field, input int unsigned got,
                                   input int unsigned due);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, due);
        mismatch_count++;
    endtask

    task automatic push_item(input logic [IDW-1:0] id, input logic [PROBW-1:0] lik);
        t_fusion_item it;
        it.id = id;
        it.lik = lik;
        likelihood_q.insert(likelihood_q.size(), it);
    endtask

    task automatic queue_pass(input t_pass_kind kind);
        logic [IDW-1:0]   id;
        logic [PROBW-1:0] peak;
        logic [PROBW-1:0] lik;
        int unsigned      c1;
        int unsigned      c2;
        int unsigned      k;
        id = ($urandom_range(0, 4) < 3) ? hot_ids[$urandom_range(0, 5)]
                                        : IDW'($urandom_range(0, 4095));
        peak = PROBW'($urandom_range(1, 65535));
        c1 = $urandom_range(0, NUM_CLASSES - 1);
        c2 = $urandom_range(0, NUM_CLASSES - 1);
        for (k = 0; k < NUM_CLASSES; k++) begin
            case (kind)
                PASS_MIXED:  lik = pick_likelihood();
                PASS_PEAKED: lik = (k == c1 || k == c2) ? peak : '0;
                PASS_FLAT:   lik = peak;
                PASS_SILENT: lik = '0;
                default: begin
                    id = IDW'($urandom_range(0, 4095));
                    lik = PROBW'($urandom_range(0, 65535));
                end
            endcase
            push_item(id, lik);
        end
    endtask

    task automatic write_threshold(input logic [PROBW-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        report_floor = v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Hold until every item is in and every result is out, then let the block settle
    task automatic wait_settled();
        while (likelihood_q.size() != 0 || i_valid || fusion_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Stimulus: reset, directed passes, then random phases under several thresholds
    initial begin : stimulus
        int unsigned      i;
        int unsigned      ph;
        int unsigned      p;
        int unsigned      r;
        logic [PROBW-1:0] floor_v;
        for (i = 0; i < TABLE_DEPTH; i++)
            prob_model[i] = PROBW'((65536 / NUM_CLASSES > 65535) ? 65535 : 65536 / NUM_CLASSES);
        norm_acc = '0;
        next_class = 0;
        report_floor = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_threshold(16'h0000);

        // All-zero likelihoods: zero denominator, empty result
        for (i = 0; i < NUM_CLASSES; i++)
            push_item(12'd0, 16'h0000);
        // First class lands on another element; only class 9 survives on the last
        // element, so the untouched class 0 and class 9 both saturate and tie
        push_item(12'd7, 16'h0000);
        for (i = 1; i < NUM_CLASSES; i++)
            push_item(12'd4095, (i == 9) ? 16'hFFFF : 16'h0000);
        wait_settled();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: floor_v = 16'hFFFF;
                1: floor_v = PROBW'($urandom_range(1, 65534));
                2: floor_v = 16'h8000;
                3: floor_v = PROBW'($urandom_range(0, 65535));
                default: floor_v = 16'h0000;
            endcase
            write_threshold(floor_v);
            for (p = 0; p < PHASE_PASSES; p++) begin
                r = $urandom_range(0, 19);
                if (r < 12) queue_pass(PASS_MIXED);
                else if (r < 14) queue_pass(PASS_PEAKED);
                else if (r < 15) queue_pass(PASS_FLAT);
                else if (r < 16) queue_pass(PASS_SILENT);
                else queue_pass(PASS_SCATTER);
            end
            wait_settled();
        end

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Driver: present the next item after its drawn gap; hold it until transferred
    always @(negedge i_clk) begin : drive_items
        t_fusion_item nxt;
        if (i_rst_n && !(i_valid && !in_xfer)) begin
            if (i_valid) begin
                if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
                gap_left = pick_wait(send_calm);
            end
            if (gap_left == 0 && likelihood_q.size() != 0) begin
                nxt = likelihood_q.pop_front();
                i_element_id <= nxt.id;
                i_likelihood <= nxt.lik;
                i_valid <= 1'b1;
            end else begin
                if (gap_left > 0) gap_left--;
                i_valid <= 1'b0;
            end
        end
    end

    // Result side: stall for a drawn number of cycles after each transfer
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_xfer) begin
                if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
                stall_left = pick_wait(recv_calm);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Monitor: check results against the oldest prediction, then predict new items
    always @(posedge i_clk) begin : monitor
        t_fusion_result due;
        in_xfer <= i_rst_n && i_valid && o_ready;
        out_xfer <= i_rst_n && o_valid && i_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (fusion_results_due.size() == 0) begin
                report_mismatch("unexpected result, winning_class", o_winning_class, 0);
            end else begin
                due = fusion_results_due.pop_front();
                if (o_has_class !== due.has_class)
                    report_mismatch("has_class", o_has_class, due.has_class);
                if (o_winning_class !== due.cls)
                    report_mismatch("winning_class", o_winning_class, due.cls);
                if (o_winning_prob !== due.prob)
                    report_mismatch("winning_prob", o_winning_prob, due.prob);
            end
        end
        if (i_rst_n && i_valid && o_ready)
            fuse_item(i_element_id, i_likelihood);

        // Watchdog: count cycles without any transfer
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
